>>> src/srfp_pkg.sv
package srfp_pkg;

	// Geometry arithmetic width: holds coordinates and window sizes up to 1024
	localparam int GEO_W = 11;
	// Window offset and row fields, sized for the largest panel and store
	localparam int DX_W = 10;
	localparam int ROW_W = 8;
	localparam int COL_W = 8;
	localparam int IDX_W = 6;

	// Source line width is fixed by the frame format
	localparam int SRC_W = 256;

	// Draw window used when upscaling is off
	localparam int NORM_WIN_W = 288;
	localparam int NORM_WIN_H = 216;

	// Reciprocal division: numerators stay below 2^NUM_W, divisors at most 1024,
	// so a shift of NUM_W + 10 gives the exact floor quotient
	localparam int NUM_W = 18;
	localparam int RECIP_SH = 28;
	localparam int RECIP_W = 21;
	localparam int PROD_W = NUM_W + RECIP_W;

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// Register indexes on the configuration port
	localparam logic REG_UPSCALE = 1'b0;
	localparam logic REG_FLIPPED = 1'b1;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_PRESENT = 1'b1
	} kind_t;

	typedef struct packed {
		logic upscale;
		logic flipped;
	} cfg_t;

	typedef struct packed {
		kind_t kind;
		logic in_win;
		logic [DX_W-1:0] dx;
		logic [DX_W-1:0] dy;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [IDX_W-1:0] data;
	} item_t;

endpackage

>>> src/srfp_front.sv
module srfp_front #(
	parameter int LOGICAL_WIDTH = 320,
	parameter int LOGICAL_HEIGHT = 240,
	parameter int KEPT_ROWS = 224,
	parameter int FIRST_KEPT_ROW = 8
) (
	input srfp_pkg::cfg_t cfg,
	input logic operation,
	input logic [7:0] source_line,
	input logic [7:0] source_column,
	input logic [15:0] pixel_word,
	input logic [8:0] panel_row,
	input logic [7:0] panel_column,
	output logic keep,
	output srfp_pkg::item_t item
);

	localparam int GW = srfp_pkg::GEO_W;
	localparam logic [GW-1:0] LW_C = GW'(LOGICAL_WIDTH);
	localparam logic [GW-1:0] LH_C = GW'(LOGICAL_HEIGHT);
	localparam logic [GW-1:0] NWW_C = GW'(srfp_pkg::NORM_WIN_W);
	localparam logic [GW-1:0] NWH_C = GW'(srfp_pkg::NORM_WIN_H);
	localparam logic [GW-1:0] LEFT_N = GW'((LOGICAL_WIDTH - srfp_pkg::NORM_WIN_W) / 2);
	localparam logic [GW-1:0] TOP_N = GW'((LOGICAL_HEIGHT - srfp_pkg::NORM_WIN_H) / 2);
	localparam logic [GW-1:0] FIRST_C = GW'(FIRST_KEPT_ROW);
	localparam logic [GW-1:0] END_C = GW'(FIRST_KEPT_ROW + KEPT_ROWS);

	logic [GW-1:0] win_w, win_h, left, top;
	logic [GW-1:0] lx, pc, ly, dx_raw, dy_raw, dx_f, dy_f;
	logic [GW-1:0] line_w, row_w;
	logic in_panel, in_win, keep_line;

	// Select draw window and its centered origin
	always_comb begin
		win_w = cfg.upscale ? LW_C : NWW_C;
		win_h = cfg.upscale ? LH_C : NWH_C;
		left = cfg.upscale ? '0 : LEFT_N;
		top = cfg.upscale ? '0 : TOP_N;
	end

	// Map panel pixel to window offsets, mirror when flipped
	always_comb begin
		lx = GW'(panel_row);
		pc = GW'(panel_column);
		in_panel = (lx < LW_C) && (pc < LH_C);
		ly = LH_C - GW'(1) - pc;
		in_win = in_panel && (lx >= left) && (lx < left + win_w)
			&& (ly >= top) && (ly < top + win_h);
		dx_raw = lx - left;
		dy_raw = ly - top;
		dx_f = cfg.flipped ? (win_w - GW'(1) - dx_raw) : dx_raw;
		dy_f = cfg.flipped ? (win_h - GW'(1) - dy_raw) : dy_raw;
	end

	// Classify writes by kept line range
	always_comb begin
		line_w = GW'(source_line);
		keep_line = (line_w >= FIRST_C) && (line_w < END_C);
		row_w = line_w - FIRST_C;
	end

	// Build the queue entry; drop writes to lines outside the store
	always_comb begin
		keep = (operation == srfp_pkg::KIND_PRESENT) || keep_line;
		item.kind = srfp_pkg::kind_t'(operation);
		item.in_win = in_win;
		item.dx = dx_f[srfp_pkg::DX_W-1:0];
		item.dy = dy_f[srfp_pkg::DX_W-1:0];
		item.row = row_w[srfp_pkg::ROW_W-1:0];
		item.col = source_column;
		item.data = pixel_word[srfp_pkg::IDX_W-1:0];
	end

endmodule

>>> src/srfp_queue.sv
module srfp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input srfp_pkg::item_t wr_item,
	input logic pop,
	output srfp_pkg::item_t rd_item,
	output logic head_valid,
	output logic full
);

	localparam int PW = srfp_pkg::Q_PTR_W;
	localparam int CW = srfp_pkg::Q_CNT_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(srfp_pkg::Q_DEPTH);

	srfp_pkg::item_t slot_q [srfp_pkg::Q_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head_valid = (cnt_q != '0);
	assign full = (cnt_q == DEPTH_C);
	assign rd_item = slot_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			priority if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= DEPTH_C)
		else $error("queue occupancy exceeds depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && full |-> pop)
		else $error("queue pushed while full");

endmodule

>>> src/srfp_back.sv
module srfp_back #(
	parameter int LOGICAL_WIDTH = 320,
	parameter int LOGICAL_HEIGHT = 240,
	parameter int KEPT_ROWS = 224
) (
	input logic clk,
	input logic arst_n,
	input srfp_pkg::cfg_t cfg,
	input logic head_valid,
	input srfp_pkg::item_t head,
	output logic pop,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic inside_window,
	output logic [5:0] palette_index
);

	localparam int NW = srfp_pkg::NUM_W;
	localparam int RCW = srfp_pkg::RECIP_W;
	localparam int PW = srfp_pkg::PROD_W;
	localparam int SH = srfp_pkg::RECIP_SH;
	localparam int CLW = srfp_pkg::COL_W;
	localparam int IW = srfp_pkg::IDX_W;
	localparam int RWID = (KEPT_ROWS > 1) ? $clog2(KEPT_ROWS) : 1;
	localparam int AW = RWID + CLW;
	localparam int DEPTH = KEPT_ROWS * srfp_pkg::SRC_W;
	localparam logic [63:0] ONE_SH = 64'd1 << SH;
	localparam logic [RCW-1:0] RCP_XN =
		RCW'((ONE_SH + 64'(srfp_pkg::NORM_WIN_W) - 64'd1) / 64'(srfp_pkg::NORM_WIN_W));
	localparam logic [RCW-1:0] RCP_YN =
		RCW'((ONE_SH + 64'(srfp_pkg::NORM_WIN_H) - 64'd1) / 64'(srfp_pkg::NORM_WIN_H));
	localparam logic [RCW-1:0] RCP_XU =
		RCW'((ONE_SH + 64'(LOGICAL_WIDTH) - 64'd1) / 64'(LOGICAL_WIDTH));
	localparam logic [RCW-1:0] RCP_YU =
		RCW'((ONE_SH + 64'(LOGICAL_HEIGHT) - 64'd1) / 64'(LOGICAL_HEIGHT));
	localparam logic [NW-1:0] KEPT_C = NW'(KEPT_ROWS);

	logic en;
	logic [RCW-1:0] rcp_x, rcp_y;
	logic [PW-1:0] prod_x, prod_y;
	logic [CLW-1:0] sx, sy;

	logic vld_s1, inside_s1;
	srfp_pkg::kind_t kind_s1;
	logic [NW-1:0] numx_s1, numy_s1;
	logic [srfp_pkg::ROW_W-1:0] row_s1;
	logic [CLW-1:0] col_s1;
	logic [IW-1:0] data_s1;

	logic vld_s2, inside_s2;
	srfp_pkg::kind_t kind_s2;
	logic [AW-1:0] addr_s2;
	logic [IW-1:0] data_s2;

	logic vld_s3, inside_s3;
	logic [IW-1:0] rd_q;
	logic [IW-1:0] store_q [DEPTH];

	// Whole back end holds while a result waits
	assign en = !(vld_s3 && rsp_stall);
	assign pop = en && head_valid;

	// Divide by the window size through a constant reciprocal
	always_comb begin
		rcp_x = cfg.upscale ? RCP_XU : RCP_XN;
		rcp_y = cfg.upscale ? RCP_YU : RCP_YN;
		prod_x = PW'(numx_s1) * PW'(rcp_x);
		prod_y = PW'(numy_s1) * PW'(rcp_y);
		sx = prod_x[SH+CLW-1:SH];
		sy = prod_y[SH+CLW-1:SH];
	end

	// Stage 1: scale numerators
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= head.kind;
			inside_s1 <= head.in_win;
			numx_s1 <= {head.dx, {CLW{1'b0}}};
			numy_s1 <= NW'(head.dy) * KEPT_C;
			row_s1 <= head.row;
			col_s1 <= head.col;
			data_s1 <= head.data;
		end
	end

	// Stage 2: form the store address
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s2 <= kind_s1;
			inside_s2 <= inside_s1;
			data_s2 <= data_s1;
			addr_s2 <= (kind_s1 == srfp_pkg::KIND_WRITE) ?
				{row_s1[RWID-1:0], col_s1} : {sy[RWID-1:0], sx};
		end
	end

	// Stage 3: write or read the frame store
	always_ff @(posedge clk) begin
		if (en && vld_s2) begin
			if (kind_s2 == srfp_pkg::KIND_WRITE) begin
				store_q[addr_s2] <= data_s2;
			end else begin
				rd_q <= store_q[addr_s2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s3 <= inside_s2;
		end
	end

	// Advance valid bits; only presents produce a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= head_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2 && (kind_s2 == srfp_pkg::KIND_PRESENT);
		end
	end

	assign rsp_valid = vld_s3;
	assign inside_window = inside_s3;
	assign palette_index = inside_s3 ? rd_q : '0;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s2 && (kind_s2 == srfp_pkg::KIND_WRITE) |=> !vld_s3)
		else $error("store write produced a result");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && rsp_stall |=> $stable(vld_s2) && $stable(inside_s3) && $stable(vld_s1))
		else $error("pipeline moved during output stall");

endmodule

>>> src/scaled_rotated_frame_presenter_core.sv
// A present transfer's result passes the queue, the scale stage, the reciprocal
// stage and the store access with registered read. Throughput: one item per
// cycle while rsp_stall is low, set by the single store port used once per item.
// Writes to lines outside the kept range are accepted and dropped at once.
// Reset clears configuration, queue and pipeline valid bits; frame store contents
// are undefined until written, with no clearing pass.
module scaled_rotated_frame_presenter_core #(
	parameter int LOGICAL_WIDTH = 320,
	parameter int LOGICAL_HEIGHT = 240,
	parameter int KEPT_ROWS = 224,
	parameter int FIRST_KEPT_ROW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic req_valid,
	output logic req_stall,
	input logic operation,
	input logic [7:0] source_line,
	input logic [7:0] source_column,
	input logic [15:0] pixel_word,
	input logic [8:0] panel_row,
	input logic [7:0] panel_column,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic inside_window,
	output logic [5:0] palette_index
);

	srfp_pkg::cfg_t cfg_q;
	srfp_pkg::item_t front_item, head_item;
	logic keep, push, pop, head_valid, q_full;

	assign pready = 1'b1;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				srfp_pkg::REG_UPSCALE: cfg_q.upscale <= pwdata[0];
				srfp_pkg::REG_FLIPPED: cfg_q.flipped <= pwdata[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[2])
			srfp_pkg::REG_UPSCALE: prdata = {31'b0, cfg_q.upscale};
			srfp_pkg::REG_FLIPPED: prdata = {31'b0, cfg_q.flipped};
			default: prdata = '0;
		endcase
	end

	srfp_front #(
		.LOGICAL_WIDTH(LOGICAL_WIDTH),
		.LOGICAL_HEIGHT(LOGICAL_HEIGHT),
		.KEPT_ROWS(KEPT_ROWS),
		.FIRST_KEPT_ROW(FIRST_KEPT_ROW)
	) u_front (
		.cfg(cfg_q),
		.operation(operation),
		.source_line(source_line),
		.source_column(source_column),
		.pixel_word(pixel_word),
		.panel_row(panel_row),
		.panel_column(panel_column),
		.keep(keep),
		.item(front_item)
	);

	// Accept while the queue has room
	assign req_stall = q_full;
	assign push = req_valid && !q_full && keep;

	srfp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_item(front_item),
		.pop(pop),
		.rd_item(head_item),
		.head_valid(head_valid),
		.full(q_full)
	);

	srfp_back #(
		.LOGICAL_WIDTH(LOGICAL_WIDTH),
		.LOGICAL_HEIGHT(LOGICAL_HEIGHT),
		.KEPT_ROWS(KEPT_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head_valid(head_valid),
		.head(head_item),
		.pop(pop),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.inside_window(inside_window),
		.palette_index(palette_index)
	);

endmodule
